### hw/rtl/fard_pkg.sv
// Shared constants, types and register codes for the framed reading to duty block.
package fard_pkg;

  // Frame delimiters and fixed characters.
  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_ETX   = 8'h03;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_LOW_R = 8'h72;
  localparam logic [7:0] CHAR_UP_P  = 8'h50;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_B  = 8'h42;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;

  // Only the first nine positions of a frame are kept.
  localparam int FRAME_DEPTH = 9;

  // Default wrap of the write index.
  localparam int STORE_WRAP_DEF = 32;

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam logic [2:0] REG_A_ZERO = 3'd0;
  localparam logic [2:0] REG_A_FULL = 3'd1;
  localparam logic [2:0] REG_A_LOW  = 3'd2;
  localparam logic [2:0] REG_A_HIGH = 3'd3;
  localparam logic [2:0] REG_B_ZERO = 3'd4;
  localparam logic [2:0] REG_B_FULL = 3'd5;
  localparam logic [2:0] REG_B_LOW  = 3'd6;
  localparam logic [2:0] REG_B_HIGH = 3'd7;

  // Register reset values.
  localparam logic [15:0] ZERO_CODE_RST = 16'd100;
  localparam logic [15:0] FULL_CODE_RST = 16'd1000;
  localparam logic [15:0] LOW_RST       = 16'd0;
  localparam logic [15:0] HIGH_RST      = 16'd999;

  // Clamp status codes.
  localparam logic [1:0] STATUS_IN    = 2'd0;
  localparam logic [1:0] STATUS_BELOW = 2'd1;
  localparam logic [1:0] STATUS_ABOVE = 2'd2;

  // Limits and codes of one channel.
  typedef struct packed {
    logic [15:0]        zero;
    logic [15:0]        full;
    logic signed [15:0] low;
    logic signed [15:0] high;
  } chan_cfg_t;

  // Decoded view of the stored frame.
  typedef struct packed {
    logic               ok;
    logic               ch;
    logic signed [10:0] reading;
  } frame_info_t;

endpackage

### hw/rtl/fard_frame.sv
// Frame byte store, write index and decode of the stored frame.
module fard_frame import fard_pkg::*; #(
  parameter int STORE_WRAP = STORE_WRAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [7:0]  rx_byte,
  output frame_info_t info
);

  localparam int IdxW = $clog2(STORE_WRAP);

  logic [7:0]      store [FRAME_DEPTH];
  logic [IdxW-1:0] write_index;
  logic [IdxW-1:0] write_index_next;

  // Index advances and wraps on every stored or dropped byte.
  always_comb begin
    if (write_index == IdxW'(STORE_WRAP - 1)) begin
      write_index_next = '0;
    end else begin
      write_index_next = write_index + 1'b1;
    end
  end

  // STX rewinds, ETX leaves the store alone, anything else is written if the index is inside the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      for (int i = 0; i < FRAME_DEPTH; i++) begin
        store[i] <= '0;
      end
    end else if (wr_en) begin
      if (rx_byte == BYTE_STX) begin
        write_index <= '0;
      end else if (rx_byte != BYTE_ETX) begin
        for (int i = 0; i < FRAME_DEPTH; i++) begin
          if (write_index == IdxW'(i)) begin
            store[i] <= rx_byte;
          end
        end
        write_index <= write_index_next;
      end
    end
  end

  // Decode of prefix, channel, sign and three digits.
  logic        prefix_ok;
  logic        digits_ok;
  logic        chan_ok;
  logic [3:0]  d0, d1, d2;
  logic [9:0]  magnitude;

  always_comb begin
    prefix_ok = (store[0] == CHAR_ZERO) && (store[1] == CHAR_ONE) &&
                (store[2] == CHAR_LOW_R) && (store[3] == CHAR_UP_P);
    chan_ok   = (store[4] == CHAR_UP_A) || (store[4] == CHAR_UP_B);
    digits_ok = 1'b1;
    for (int i = 6; i < FRAME_DEPTH; i++) begin
      if (store[i] < CHAR_ZERO || store[i] > CHAR_NINE) begin
        digits_ok = 1'b0;
      end
    end
    d0 = 4'(store[6] - CHAR_ZERO);
    d1 = 4'(store[7] - CHAR_ZERO);
    d2 = 4'(store[8] - CHAR_ZERO);
    magnitude = 10'(d0) * 10'd100 + 10'(d1) * 10'd10 + 10'(d2);
    info.ok = prefix_ok && chan_ok && digits_ok;
    info.ch = (store[4] == CHAR_UP_B);
    if (store[5] == CHAR_UP_F) begin
      info.reading = -$signed({1'b0, magnitude});
    end else begin
      info.reading = $signed({1'b0, magnitude});
    end
  end

endmodule

### hw/rtl/fard_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit 16 bits.
module fard_div import fard_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  localparam int DivSteps = 16;
  localparam int CntW     = $clog2(DivSteps);

  logic [15:0]     rem;
  logic [15:0]     quo;
  logic [15:0]     den;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [17:0]     diff;
  logic            fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    diff = {1'b0, rem, quo[15]} - {2'b00, den};
    fits = ~diff[17];
  end

  // The upper half is already below the divisor, so sixteen steps suffice.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CntW'(DivSteps - 1));
      if (start) begin
        rem  <= dividend[31:16];
        quo  <= dividend[15:0];
        den  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[15:0] : {rem[14:0], quo[15]};
        quo <= {quo[14:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DivSteps - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### hw/rtl/framed_ascii_reading_to_duty.sv
// Top level: configuration registers, ETX sequencer and result register.
// Bytes arrive on the rx channel one transfer at a time; STX and data bytes are taken
// without a stall. An ETX stalls rx while the stored frame is checked. A frame that
// fails the check, or a channel with equal limits, goes back to idle from the check
// with no result. A reading outside the channel limits is clamped to the zero or full
// code in the check and goes on to the output state. A reading inside the limits
// passes the check, the multiply, the divider start, the bit-serial divider and the
// pickup of the quotient, in that order, before its result is loaded; most of that
// stall is spent in the divider. The result waits in an output register, and rx is
// taken again while it waits, but a further ETX holds in the output state until the
// register is free, which adds the cycles that the result side stalls.
module framed_ascii_reading_to_duty import fard_pkg::*; #(
  parameter int STORE_WRAP = STORE_WRAP_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Received byte channel.
  input  logic                rx_valid,
  output logic                rx_stall,
  input  logic [7:0]          rx_byte,
  // Result channel.
  output logic                res_valid,
  input  logic                res_stall,
  output logic                channel,
  output logic [15:0]         duty_code,
  output logic signed [10:0]  reading_tenths,
  output logic [1:0]          clamp_status,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  state_t             state;
  chan_cfg_t          cfg_a;
  chan_cfg_t          cfg_b;
  chan_cfg_t          cfg_sel;
  frame_info_t        info;
  logic               rx_take;
  logic [2:0]         reg_idx;

  logic               ch_r;
  logic signed [10:0] reading_r;
  logic [1:0]         status_r;
  logic [15:0]        code_r;
  logic [15:0]        zero_r;
  logic [15:0]        num_r;
  logic [15:0]        den_r;
  logic [15:0]        span_r;
  logic [31:0]        prod_r;
  logic               div_start;
  logic               div_done;
  logic [15:0]        div_quo;

  assign rx_stall = (state != S_IDLE);
  assign rx_take  = rx_valid && !rx_stall;
  assign pready   = 1'b1;
  assign reg_idx  = paddr[PADDR_W-1:2];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_a <= '{zero: ZERO_CODE_RST, full: FULL_CODE_RST, low: LOW_RST, high: HIGH_RST};
      cfg_b <= '{zero: ZERO_CODE_RST, full: FULL_CODE_RST, low: LOW_RST, high: HIGH_RST};
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_A_ZERO: cfg_a.zero <= pwdata[15:0];
        REG_A_FULL: cfg_a.full <= pwdata[15:0];
        REG_A_LOW:  cfg_a.low  <= pwdata[15:0];
        REG_A_HIGH: cfg_a.high <= pwdata[15:0];
        REG_B_ZERO: cfg_b.zero <= pwdata[15:0];
        REG_B_FULL: cfg_b.full <= pwdata[15:0];
        REG_B_LOW:  cfg_b.low  <= pwdata[15:0];
        REG_B_HIGH: cfg_b.high <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_A_ZERO: prdata = PDATA_W'(cfg_a.zero);
      REG_A_FULL: prdata = PDATA_W'(cfg_a.full);
      REG_A_LOW:  prdata = PDATA_W'(cfg_a.low);
      REG_A_HIGH: prdata = PDATA_W'(cfg_a.high);
      REG_B_ZERO: prdata = PDATA_W'(cfg_b.zero);
      REG_B_FULL: prdata = PDATA_W'(cfg_b.full);
      REG_B_LOW:  prdata = PDATA_W'(cfg_b.low);
      REG_B_HIGH: prdata = PDATA_W'(cfg_b.high);
      default:    prdata = '0;
    endcase
  end

  // Frame store and decode.
  fard_frame #(
    .STORE_WRAP (STORE_WRAP)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rx_take),
    .rx_byte (rx_byte),
    .info    (info)
  );

  // Divider for the scaled reading.
  fard_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Limit comparison on the decoded reading.
  logic signed [16:0] reading_ext;
  logic signed [16:0] low_ext;
  logic signed [16:0] high_ext;
  logic signed [16:0] num_full;
  logic signed [16:0] den_full;

  always_comb begin
    cfg_sel     = info.ch ? cfg_b : cfg_a;
    reading_ext = 17'(info.reading);
    low_ext     = 17'(cfg_sel.low);
    high_ext    = 17'(cfg_sel.high);
    num_full    = reading_ext - low_ext;
    den_full    = high_ext - low_ext;
  end

  // Sequencer with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      // The divider starts in the cycle after the product is formed.
      div_start <= (state == S_MUL);
      // A transfer empties the result register unless a new result is loaded now.
      if (res_valid && !res_stall && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (rx_take && rx_byte == BYTE_ETX) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          ch_r      <= info.ch;
          reading_r <= info.reading;
          zero_r    <= cfg_sel.zero;
          num_r     <= num_full[15:0];
          den_r     <= den_full[15:0];
          span_r    <= cfg_sel.full - cfg_sel.zero + 16'd1;
          if (!info.ok || cfg_sel.low == cfg_sel.high) begin
            state <= S_IDLE;
          end else if (reading_ext < low_ext) begin
            code_r   <= cfg_sel.zero;
            status_r <= STATUS_BELOW;
            state    <= S_OUT;
          end else if (reading_ext > high_ext) begin
            code_r   <= cfg_sel.full;
            status_r <= STATUS_ABOVE;
            state    <= S_OUT;
          end else begin
            status_r <= STATUS_IN;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= num_r * span_r;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            code_r <= zero_r + div_quo;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            channel        <= ch_r;
            duty_code      <= code_r;
            reading_tenths <= reading_r;
            clamp_status   <= status_r;
            res_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### test/framed_ascii_reading_to_duty_tb.sv
// Self-checking testbench for the framed ASCII reading to duty code block.
`timescale 1ns / 1ps

module framed_ascii_reading_to_duty_tb;
  import fard_pkg::*;

  localparam int WRAP          = STORE_WRAP_DEF;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 160;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int REPORT_LIMIT  = 100;

  // One duty code result as it leaves the block.
  typedef struct packed {
    logic               ch;
    logic [15:0]        duty;
    logic signed [10:0] reading;
    logic [1:0]         status;
  } duty_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic               channel;
  logic [15:0]        duty_code;
  logic signed [10:0] reading_tenths;
  logic [1:0]         clamp_status;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Bytes waiting to be sent, and the duty results still owed by the block.
  logic [7:0]   rx_pending [$];
  duty_result_t duty_due [$];

  // Copy of the block's frame store, write index and channel limits.
  logic [7:0] frame_bytes [FRAME_DEPTH];
  int         frame_pos;
  chan_cfg_t  chan_limits [2];

  logic [7:0] body_buf [FRAME_DEPTH];
  int         bytes_queued = 0;
  int         bytes_taken = 0;
  int         errors = 0;
  int         gap_max = 0;
  int         hold_max = 0;
  int         tx_wait = 0;
  int         hold_left = 0;
  int         cycles = 0;

  framed_ascii_reading_to_duty #(.STORE_WRAP(WRAP)) dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .channel        (channel),
    .duty_code      (duty_code),
    .reading_tenths (reading_tenths),
    .clamp_status   (clamp_status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Works out the duty result, if any, that one received byte causes.
  function automatic bit predict_duty(input logic [7:0] b, output duty_result_t r);
    int              rd;
    int              lo;
    int              hi;
    longint unsigned num;
    longint unsigned den;
    longint unsigned span;
    logic [15:0]     code;
    logic [1:0]      status;
    logic            ch;
    chan_cfg_t       c;
    r = '0;
    if (b == BYTE_STX) begin
      frame_pos = 0;
      return 1'b0;
    end
    if (b != BYTE_ETX) begin
      if (frame_pos < FRAME_DEPTH) frame_bytes[frame_pos] = b;
      frame_pos = (frame_pos + 1) % WRAP;
      return 1'b0;
    end
    if (frame_bytes[0] != CHAR_ZERO || frame_bytes[1] != CHAR_ONE ||
        frame_bytes[2] != CHAR_LOW_R || frame_bytes[3] != CHAR_UP_P) return 1'b0;
    if (frame_bytes[4] == CHAR_UP_A) ch = 1'b0;
    else if (frame_bytes[4] == CHAR_UP_B) ch = 1'b1;
    else return 1'b0;
    for (int i = 6; i < FRAME_DEPTH; i++) begin
      if (frame_bytes[i] < CHAR_ZERO || frame_bytes[i] > CHAR_NINE) return 1'b0;
    end
    rd = int'(frame_bytes[6] - CHAR_ZERO) * 100 + int'(frame_bytes[7] - CHAR_ZERO) * 10 +
         int'(frame_bytes[8] - CHAR_ZERO);
    if (frame_bytes[5] == CHAR_UP_F) rd = -rd;
    c  = chan_limits[ch];
    lo = $signed(c.low);
    hi = $signed(c.high);
    // Equal limits leave the scale undefined, so the frame is dropped.
    if (lo == hi) return 1'b0;
    if (rd < lo) begin
      code   = c.zero;
      status = STATUS_BELOW;
    end else if (rd > hi) begin
      code   = c.full;
      status = STATUS_ABOVE;
    end else begin
      num    = rd - lo;
      den    = hi - lo;
      span   = (c.full - c.zero + 1) & 64'hFFFF;
      code   = c.zero + (num * span) / den;
      status = STATUS_IN;
    end
    r.ch      = ch;
    r.duty    = code;
    r.reading = rd[10:0];
    r.status  = status;
    return 1'b1;
  endfunction

  // Counts a mismatch and reports it, up to a limit.
  task automatic report(input string what, input int want, input int got);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // Compares one result transfer with the oldest expectation.
  task automatic check_result();
    duty_result_t want;
    if (duty_due.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: result with none expected, channel %0d duty %0d reading %0d status %0d",
                 $time, channel, duty_code, reading_tenths, clamp_status);
      return;
    end
    want = duty_due.pop_front();
    if (channel !== want.ch) report("channel", want.ch, channel);
    if (duty_code !== want.duty) report("duty_code", want.duty, duty_code);
    if (reading_tenths !== want.reading) report("reading_tenths", want.reading, reading_tenths);
    if (clamp_status !== want.status) report("clamp_status", want.status, clamp_status);
  endtask

  // Driver: presents queued bytes, with a random idle gap after each transfer.
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
      tx_wait  <= 0;
    end else if (!rx_valid || !rx_stall) begin
      if (tx_wait != 0) begin
        rx_valid <= 1'b0;
        tx_wait  <= tx_wait - 1;
      end else if (rx_pending.size() != 0) begin
        rx_byte  <= rx_pending.pop_front();
        rx_valid <= 1'b1;
        tx_wait  <= $urandom_range(0, gap_max);
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks result transfers, predicts from byte transfers and drives
  // a random stall after each result.
  always @(posedge clk) begin
    duty_result_t due;
    if (rst) begin
      res_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_valid && !res_stall) check_result();
      if (rx_valid && !rx_stall) begin
        bytes_taken++;
        if (predict_duty(rx_byte, due)) duty_due.push_back(due);
      end
      if (res_valid && !res_stall) begin
        hold_left = $urandom_range(0, hold_max);
        res_stall <= (hold_left != 0);
      end else if (hold_left > 1) begin
        hold_left = hold_left - 1;
      end else begin
        hold_left = 0;
        res_stall <= 1'b0;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Any byte value apart from the two delimiters.
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_STX || b == BYTE_ETX);
    return b;
  endfunction

  // A digit position: mostly a digit, now and then a byte just outside the range or any other data byte.
  function automatic logic [7:0] digit_byte(input int mode);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return CHAR_ZERO - 8'd1;
    if (pick < 8) return CHAR_NINE + 8'd1;
    if (pick < 10) return data_byte();
    if (mode == 0) return CHAR_ZERO;
    if (mode == 1) return CHAR_NINE;
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Builds the nine kept bytes of a frame with random content and rare damage.
  task automatic fill_body();
    int pick;
    int mode;
    body_buf[0] = CHAR_ZERO;
    body_buf[1] = CHAR_ONE;
    body_buf[2] = CHAR_LOW_R;
    body_buf[3] = CHAR_UP_P;
    for (int i = 0; i < 4; i++) if ($urandom_range(0, 99) < 4) body_buf[i] = data_byte();
    pick = $urandom_range(0, 99);
    body_buf[4] = (pick < 45) ? CHAR_UP_A : (pick < 90) ? CHAR_UP_B : data_byte();
    body_buf[5] = ($urandom_range(0, 1) != 0) ? CHAR_UP_F : data_byte();
    pick = $urandom_range(0, 99);
    mode = (pick < 10) ? 0 : (pick < 20) ? 1 : 2;
    for (int i = 6; i < FRAME_DEPTH; i++) body_buf[i] = digit_byte(mode);
  endtask

  // Queues one piece of traffic: mostly whole frames, the rest broken ones and noise.
  task automatic queue_traffic();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    fill_body();
    if (pick < 60) begin
      push_byte(BYTE_STX);
      for (int i = 0; i < FRAME_DEPTH; i++) push_byte(body_buf[i]);
      push_byte(BYTE_ETX);
    end else if (pick < 68) begin
      // Short frame: the tail of the previous frame is checked.
      n = $urandom_range(0, FRAME_DEPTH - 1);
      push_byte(BYTE_STX);
      for (int i = 0; i < n; i++) push_byte(body_buf[i]);
      push_byte(BYTE_ETX);
    end else if (pick < 76) begin
      // Long frame: bytes past the store are dropped, a long tail wraps round.
      n = $urandom_range(1, 30);
      push_byte(BYTE_STX);
      for (int i = 0; i < FRAME_DEPTH; i++) push_byte(body_buf[i]);
      for (int i = 0; i < n; i++) push_byte(data_byte());
      push_byte(BYTE_ETX);
    end else if (pick < 82) begin
      // A full wrap of junk brings the index back to the start of the store.
      push_byte(BYTE_STX);
      for (int i = 0; i < WRAP; i++) push_byte(data_byte());
      for (int i = 0; i < FRAME_DEPTH; i++) push_byte(body_buf[i]);
      push_byte(BYTE_ETX);
    end else if (pick < 90) begin
      push_byte(BYTE_ETX);
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // One register write over the configuration port, mirrored in the copy.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_A_ZERO: chan_limits[0].zero = val;
      REG_A_FULL: chan_limits[0].full = val;
      REG_A_LOW:  chan_limits[0].low  = val;
      REG_A_HIGH: chan_limits[0].high = val;
      REG_B_ZERO: chan_limits[1].zero = val;
      REG_B_FULL: chan_limits[1].full = val;
      REG_B_LOW:  chan_limits[1].low  = val;
      REG_B_HIGH: chan_limits[1].high = val;
      default: ;
    endcase
  endtask

  task automatic set_channel(input bit ch, input int zero, input int full, input int lo,
                             input int hi);
    write_reg(ch ? REG_B_ZERO : REG_A_ZERO, zero[15:0]);
    write_reg(ch ? REG_B_FULL : REG_A_FULL, full[15:0]);
    write_reg(ch ? REG_B_LOW : REG_A_LOW, lo[15:0]);
    write_reg(ch ? REG_B_HIGH : REG_A_HIGH, hi[15:0]);
  endtask

  // Random limits: mostly a window that readings can fall in, sometimes degenerate.
  task automatic random_channel(input bit ch);
    int pick;
    int lo;
    int hi;
    pick = $urandom_range(0, 9);
    lo   = $urandom_range(0, 1899) - 999;
    if (pick == 0) begin
      lo = -32768;
      hi = 32767;
    end else if (pick == 1) begin
      hi = lo;
    end else if (pick == 2) begin
      hi = lo - $urandom_range(1, 500);
    end else begin
      hi = lo + $urandom_range(1, 600);
    end
    set_channel(ch, $urandom_range(0, 65535), $urandom_range(0, 65535), lo, hi);
  endtask

  // Waits until every byte has been taken and every result has come back.
  task automatic wait_idle();
    do @(posedge clk); while (bytes_taken != bytes_queued || duty_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase_end;
    for (int i = 0; i < FRAME_DEPTH; i++) frame_bytes[i] = 8'h00;
    frame_pos = 0;
    for (int c = 0; c < 2; c++)
      chan_limits[c] = '{zero: ZERO_CODE_RST, full: FULL_CODE_RST, low: LOW_RST,
                         high: HIGH_RST};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      gap_max  = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 10 : 3;
      hold_max = (p % 3 == 1) ? 0 : (p % 3 == 2) ? 10 : 3;
      case (p)
        0: begin
          // Most negative reading, a repeated check of the same frame, an
          // unsigned top reading, then the extreme byte values past the store.
          push_byte(BYTE_STX);
          push_text("01rPAF999");
          push_byte(BYTE_ETX);
          push_byte(BYTE_ETX);
          push_byte(BYTE_STX);
          push_text("01rPB 999");
          push_byte(BYTE_ETX);
          push_byte(8'hFF);
          push_byte(8'h00);
        end
        1: begin
          // Widest window, with a span that wraps to zero; reversed limits on B.
          set_channel(0, 0, 65535, -32768, 32767);
          set_channel(1, 65535, 0, 32767, -32768);
          // A negative zero reads as zero.
          push_byte(BYTE_STX);
          push_text("01rPAF000");
          push_byte(BYTE_ETX);
        end
        2: begin
          set_channel(0, $urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0);
          set_channel(1, 65535, 0, -999, 999);
        end
        3: begin
          set_channel(0, $urandom_range(0, 65535), $urandom_range(0, 65535), 999, -999);
          set_channel(1, $urandom_range(0, 65535), $urandom_range(0, 65535), -32768, -999);
        end
        default: begin
          random_channel(0);
          random_channel(1);
        end
      endcase
      phase_end = bytes_queued + PHASE_BYTES;
      while (bytes_queued < phase_end) queue_traffic();
      wait_idle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fard_pkg.sv
hw/rtl/fard_frame.sv
hw/rtl/fard_div.sv
hw/rtl/framed_ascii_reading_to_duty.sv
test/framed_ascii_reading_to_duty_tb.sv
